// File: src/u16u8_pkg.sv
// ----------------------------------------------------------------------------
// u16u8_pkg
// Shared types, constants and the UTF-8 encode function for the UTF-16 to
// UTF-8 transcoder.
// ----------------------------------------------------------------------------
package u16u8_pkg;

   // Width of the consumed-byte counter (wraps at this width)
   localparam int COUNT_BITS = 16;

   // Job queue depth between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   // Result kinds
   localparam logic KIND_DATA   = 1'b0;
   localparam logic KIND_STATUS = 1'b1;

   // Status codes
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_INVALID = 2'd1;
   localparam logic [1:0] STATUS_FULL    = 2'd2;

   // Byte order mark bytes
   localparam logic [7:0] BOM_FE = 8'hfe;
   localparam logic [7:0] BOM_FF = 8'hff;

   // Surrogate ranges
   localparam logic [15:0] HIGH_SURR_LO = 16'hd800;
   localparam logic [15:0] HIGH_SURR_HI = 16'hdbff;
   localparam logic [15:0] LOW_SURR_LO  = 16'hdc00;
   localparam logic [15:0] LOW_SURR_HI  = 16'hdfff;
   localparam logic [20:0] SUPP_BASE    = 21'h10000;

   // Lead-byte marks indexed by sequence length
   localparam logic [4:0][7:0] LEAD_MARK = {8'hf0, 8'he0, 8'hc0, 8'h00, 8'h00};

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_stream;
   } req_payload_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  data_byte;
      logic [1:0]  status;
      logic [15:0] consumed_bytes;
      logic        last;
   } rsp_payload_type;

   // UTF-8 encoding of one code point
   typedef struct packed {
      logic [2:0]      len;
      logic [3:0][7:0] bytes;   // bytes[0] goes out first
   } utf8_enc_type;

   // One queued job: up to four data bytes, then an optional status item
   typedef struct packed {
      logic [3:0][7:0]        bytes;
      logic [2:0]             nbytes;
      logic                   has_status;
      logic [1:0]             status;
      logic [15:0]            consumed;
   } job_type;

   function automatic utf8_enc_type utf8_encode(input logic [20:0] cp);
      utf8_enc_type r;
      r.bytes = '0;
      if (cp < 21'h80) begin
         r.len      = 3'd1;
         r.bytes[0] = {1'b0, cp[6:0]};
      end else if (cp < 21'h800) begin
         r.len      = 3'd2;
         r.bytes[0] = {3'b000, cp[10:6]} | LEAD_MARK[2];
         r.bytes[1] = {2'b10, cp[5:0]};
      end else if (cp < SUPP_BASE) begin
         r.len      = 3'd3;
         r.bytes[0] = {4'b0000, cp[15:12]} | LEAD_MARK[3];
         r.bytes[1] = {2'b10, cp[11:6]};
         r.bytes[2] = {2'b10, cp[5:0]};
      end else begin
         r.len      = 3'd4;
         r.bytes[0] = {5'b00000, cp[20:18]} | LEAD_MARK[4];
         r.bytes[1] = {2'b10, cp[17:12]};
         r.bytes[2] = {2'b10, cp[11:6]};
         r.bytes[3] = {2'b10, cp[5:0]};
      end
      return r;
   endfunction

endpackage

// File: src/u16u8_front.sv
// ----------------------------------------------------------------------------
// u16u8_front
// Accepts stream bytes, tracks byte order, surrogates, space and count, and
// turns each accepted byte into at most one job for the output side.
// ----------------------------------------------------------------------------
module u16u8_front import u16u8_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [15:0]     csr_data,
   output logic            job_valid,
   input  logic            job_ready,
   output job_type         job
);

   logic [15:0]           capacity_ff, capacity_in;
   logic                  at_start_ff, at_start_in;
   logic                  phase_ff, phase_in;
   logic [7:0]            held_ff, held_in;
   logic                  le_ff, le_in;
   logic [9:0]            pend_bits_ff, pend_bits_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic [15:0]           space_ff, space_in;
   logic [1:0]            status_ff, status_in;

   logic                  accept;
   logic                  unit_valid;
   logic [15:0]           unit;
   logic                  enc_req;
   logic [20:0]           enc_cp;
   utf8_enc_type          enc;

   assign csr_ready  = 1'b1;
   assign req_ready  = job_ready;
   assign accept     = req_valid && req_ready;

   // capacity register
   always_comb begin
      capacity_in = capacity_ff;
      if (csr_valid && csr_ready) begin
         capacity_in = csr_data;
      end
   end

   // per-byte state update
   always_comb begin
      at_start_in   = at_start_ff;
      phase_in      = phase_ff;
      held_in       = held_ff;
      le_in         = le_ff;
      pend_bits_in  = pend_bits_ff;
      pend_valid_in = pend_valid_ff;
      count_in      = count_ff;
      space_in      = space_ff;
      status_in     = status_ff;
      unit_valid    = 1'b0;
      unit          = '0;
      enc_req       = 1'b0;
      enc_cp        = '0;
      job           = '0;

      // byte pairing and byte order mark
      if (!phase_ff) begin
         if (at_start_ff) begin
            space_in = capacity_ff;
         end
         held_in  = req_payload.in_byte;
         phase_in = 1'b1;
      end else begin
         phase_in = 1'b0;
         if (at_start_ff) begin
            at_start_in = 1'b0;
            if (held_ff == BOM_FE && req_payload.in_byte == BOM_FF) begin
               le_in    = 1'b0;
               count_in = count_ff + COUNT_BITS'(2);
            end else if (held_ff == BOM_FF && req_payload.in_byte == BOM_FE) begin
               le_in    = 1'b1;
               count_in = count_ff + COUNT_BITS'(2);
            end else begin
               le_in      = 1'b0;
               unit_valid = 1'b1;
               unit       = {held_ff, req_payload.in_byte};
            end
         end else begin
            unit_valid = 1'b1;
            unit = le_ff ? {req_payload.in_byte, held_ff} : {held_ff, req_payload.in_byte};
         end
      end

      // code unit handling
      if (unit_valid && status_ff == STATUS_OK) begin
         if (pend_valid_ff) begin
            pend_valid_in = 1'b0;
            pend_bits_in  = '0;
            if (unit >= LOW_SURR_LO && unit <= LOW_SURR_HI) begin
               count_in = count_in + COUNT_BITS'(2);
               enc_req  = 1'b1;
               enc_cp   = SUPP_BASE + {1'b0, pend_bits_ff, unit[9:0]};
            end else begin
               status_in = STATUS_INVALID;
            end
         end else if (space_in <= 16'd1) begin
            status_in = STATUS_FULL;
         end else begin
            count_in = count_in + COUNT_BITS'(2);
            if (unit >= HIGH_SURR_LO && unit <= HIGH_SURR_HI) begin
               pend_bits_in  = unit[9:0];
               pend_valid_in = 1'b1;
            end else if (unit >= LOW_SURR_LO && unit <= LOW_SURR_HI) begin
               status_in = STATUS_INVALID;
            end else begin
               enc_req = 1'b1;
               enc_cp  = {5'b00000, unit};
            end
         end
      end

      // unpaired high surrogate at end of stream
      if (req_payload.end_of_stream && pend_valid_in && status_in == STATUS_OK) begin
         enc_req = 1'b1;
         enc_cp  = {5'b00000, HIGH_SURR_LO[15:10], pend_bits_in};
      end

      enc = utf8_encode(enc_cp);

      // space check and data bytes
      if (enc_req) begin
         if (space_in <= {13'b0, enc.len}) begin
            status_in = STATUS_FULL;
         end else begin
            space_in   = space_in - {13'b0, enc.len};
            job.bytes  = enc.bytes;
            job.nbytes = enc.len;
         end
      end

      // status item and stream restart
      if (req_payload.end_of_stream) begin
         job.has_status = 1'b1;
         job.status     = status_in;
         job.consumed   = (status_in == STATUS_INVALID) ? 16'd0 : 16'(count_in);
         at_start_in    = 1'b1;
         phase_in       = 1'b0;
         held_in        = '0;
         le_in          = 1'b0;
         pend_bits_in   = '0;
         pend_valid_in  = 1'b0;
         count_in       = '0;
         space_in       = '0;
         status_in      = STATUS_OK;
      end
   end

   assign job_valid = req_valid && (job.nbytes != 3'd0 || job.has_status);

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff   <= 16'hffff;
         at_start_ff   <= 1'b1;
         phase_ff      <= 1'b0;
         held_ff       <= '0;
         le_ff         <= 1'b0;
         pend_bits_ff  <= '0;
         pend_valid_ff <= 1'b0;
         count_ff      <= '0;
         space_ff      <= '0;
         status_ff     <= STATUS_OK;
      end else begin
         capacity_ff <= capacity_in;
         if (accept) begin
            at_start_ff   <= at_start_in;
            phase_ff      <= phase_in;
            held_ff       <= held_in;
            le_ff         <= le_in;
            pend_bits_ff  <= pend_bits_in;
            pend_valid_ff <= pend_valid_in;
            count_ff      <= count_in;
            space_ff      <= space_in;
            status_ff     <= status_in;
         end
      end
   end

endmodule

// File: src/u16u8_queue.sv
// ----------------------------------------------------------------------------
// u16u8_queue
// Small job FIFO between the front and the output side.
// ----------------------------------------------------------------------------
module u16u8_queue import u16u8_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  job_type push_job,
   output logic    pop_valid,
   input  logic    pop,
   output job_type head_job
);

   job_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_BITS:0]   count_ff, count_in;
   logic                 do_push, do_pop;

   assign push_ready = count_ff != (QPTR_BITS+1)'(QUEUE_DEPTH);
   assign pop_valid  = count_ff != '0;
   assign head_job   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && pop_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

// File: src/u16u8_back.sv
// ----------------------------------------------------------------------------
// u16u8_back
// Unpacks queued jobs into result transactions, one per cycle while the output
// is not stalled, through an output register.
// ----------------------------------------------------------------------------
module u16u8_back import u16u8_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            job_valid,
   output logic            job_pop,
   input  job_type         job,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload
);

   logic            valid_ff, valid_in;
   rsp_payload_type data_ff, data_in;
   logic [2:0]      idx_ff, idx_in;
   logic            load;
   logic            done;

   assign load        = job_valid && (!valid_ff || rsp_ready);
   assign rsp_valid   = valid_ff;
   assign rsp_payload = data_ff;
   assign job_pop     = load && done;

   // select next piece of the head job
   always_comb begin
      data_in = '0;
      done    = 1'b0;
      if (idx_ff < job.nbytes) begin
         data_in.kind      = KIND_DATA;
         data_in.data_byte = job.bytes[idx_ff[1:0]];
         done = (idx_ff + 3'd1 == job.nbytes) && !job.has_status;
      end else begin
         data_in.kind           = KIND_STATUS;
         data_in.status         = job.status;
         data_in.consumed_bytes = job.consumed;
         data_in.last           = 1'b1;
         done                   = 1'b1;
      end
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = done ? 3'd0 : idx_ff + 3'd1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data_in;
      end
   end

endmodule

// File: src/utf16_to_utf8_transcoder_unit.sv
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder_unit
// Order: an accepted byte's job is queued, then its first result is registered.
// Throughput: one input byte per cycle into a 4-job queue while not full;
// one result per cycle out of the output register while rsp_ready is high, so
// the output port sets the sustained rate (up to 1.5 results per input byte,
// status item adds one per stream).
// Reset: synchronous; clears stream state and queue, capacity to 65535.
// ----------------------------------------------------------------------------
module utf16_to_utf8_transcoder_unit import u16u8_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   output logic            rsp_valid,
   input  logic            rsp_ready,
   output rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   output logic            csr_ready,
   input  logic [15:0]     csr_data
);

   logic    push_valid, push_ready;
   job_type push_job;
   logic    head_valid, head_pop;
   job_type head_job;

   // front: byte classification and stream state
   u16u8_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .job_valid   (push_valid),
      .job_ready   (push_ready),
      .job         (push_job)
   );

   // job queue
   u16u8_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (head_valid),
      .pop        (head_pop),
      .head_job   (head_job)
   );

   // back: result sequencing
   u16u8_back u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (head_valid),
      .job_pop     (head_pop),
      .job         (head_job),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
